>>> hw/rtl/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

   // operation codes carried in the mode field
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam int          COUNT_W   = 7;
   localparam logic [6:0]  CAP_RESET = 7'd64;

   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      count_type          entry_count;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

endpackage

>>> hw/rtl/bls_stream_if.sv
`timescale 1ns / 1ps

interface bls_stream_if #(
   parameter type PAYLOAD_TYPE = logic
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/bls_ram.sv
`timescale 1ns / 1ps

module bls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bounded_lifo_stack.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of signed 32-bit words.
// req_chan carries one item per operation: mode (push, pop, peek) and the
// word to push. rsp_chan returns one item per request: the popped or peeked
// word, a status (ok, overflow, underflow), the entry count after the
// operation and the full and empty flags.
// csr_chan writes the capacity limit; it is always ready and should only be
// written while no request is in flight. Limits above STACK_DEPTH are
// clamped to STACK_DEPTH.
// Throughput: one item per cycle while rsp_chan is not stalled. A response
// passes two stages after its request is accepted: the registered read of the
// word store RAM and the output register.
// Words live in a single-port-write, single-port-read RAM; the fill level
// is a register updated at accept, so back-to-back push/pop never touch
// the same entry in the same cycle.
// Reset clears the fill level and sets the limit to 64; RAM contents are
// not cleared (only entries below the fill level are ever read).
// When the receiver stalls, the response and one pending item are held and
// req_chan.ready drops until the output register drains.
module bounded_lifo_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   bls_stream_if.sink   req_chan,
   bls_stream_if.source rsp_chan,
   bls_stream_if.sink   csr_chan
);

   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LIM_MAX = (STACK_DEPTH > 127) ? 127 : STACK_DEPTH;
   localparam logic [bls_pkg::COUNT_W-1:0] LIM_CAP = bls_pkg::COUNT_W'(LIM_MAX);

   typedef struct packed {
      logic                valid;
      logic                rd;
      logic [1:0]          status;
      bls_pkg::count_type  count;
      logic                full;
      logic                empty;
   } stage_type;

   bls_pkg::count_type cap_ff, cap_in;
   bls_pkg::count_type fill_ff, fill_in;
   bls_pkg::count_type fill_next, lim;
   stage_type          s1_ff, s1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bls_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic              req_acc, s1_adv;
   logic              ram_we, ram_re, op_read;
   logic [1:0]        op_status;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [31:0]       ram_rdata;

   // handshakes
   assign s1_adv         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_ff.valid || s1_adv;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // operation decode against the current fill level
   always_comb begin
      lim       = (cap_ff > LIM_CAP) ? LIM_CAP : cap_ff;
      fill_next = fill_ff;
      op_status = bls_pkg::STATUS_OK;
      op_read   = 1'b0;
      ram_we    = 1'b0;
      unique case (req_chan.payload.mode) inside
         bls_pkg::MODE_PUSH: begin
            if (fill_ff >= lim) begin
               op_status = bls_pkg::STATUS_OVERFLOW;
            end else begin
               ram_we    = req_acc;
               fill_next = fill_ff + 1'b1;
            end
         end
         bls_pkg::MODE_POP, bls_pkg::MODE_PEEK: begin
            if (fill_ff == '0) begin
               op_status = bls_pkg::STATUS_UNDERFLOW;
            end else begin
               op_read = 1'b1;
               if (req_chan.payload.mode == bls_pkg::MODE_POP) begin
                  fill_next = fill_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_re    = req_acc && op_read;
   assign ram_waddr = ADDR_W'(fill_ff);
   assign ram_raddr = ADDR_W'(fill_ff - 1'b1);

   bls_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_chan.payload.push_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state: fill level, limit, read stage, output register
   always_comb begin
      fill_in = req_acc ? fill_next : fill_ff;
      cap_in  = (csr_chan.valid && csr_chan.ready) ? csr_chan.payload : cap_ff;

      s1_in = s1_ff;
      if (req_acc) begin
         s1_in.valid  = 1'b1;
         s1_in.rd     = op_read;
         s1_in.status = op_status;
         s1_in.count  = fill_next;
         s1_in.full   = (fill_next >= lim);
         s1_in.empty  = (fill_next == '0);
      end else if (s1_adv) begin
         s1_in.valid = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in            = s1_ff.valid;
         rsp_data_in.read_value  = s1_ff.rd ? ram_rdata : 32'sd0;
         rsp_data_in.status      = s1_ff.status;
         rsp_data_in.entry_count = s1_ff.count;
         rsp_data_in.is_full     = s1_ff.full;
         rsp_data_in.is_empty    = s1_ff.empty;
      end
   end

   // control registers and read stage; of the read stage only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= bls_pkg::CAP_RESET;
         s1_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

>>> bench/bounded_lifo_stack_tb.sv
`timescale 1ns / 1ps

module bounded_lifo_stack_tb;

   localparam int         STACK_DEPTH = 64;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         MAX_PRINTS  = 50;
   // mode 3 is not an operation, the block must leave the stack alone
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;

   bls_stream_if #(.PAYLOAD_TYPE(bls_pkg::req_type))   req_if ();
   bls_stream_if #(.PAYLOAD_TYPE(bls_pkg::rsp_type))   rsp_if ();
   bls_stream_if #(.PAYLOAD_TYPE(bls_pkg::count_type)) csr_if ();

   bounded_lifo_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predicted stack contents and settings
   logic signed [31:0]  stack_words [STACK_DEPTH];
   bls_pkg::count_type  stack_level;
   bls_pkg::count_type  stack_cap;
   bls_pkg::rsp_type    due_stack_rsps [$];

   int   error_count;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_active;
   event long_hold_go;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("bounded_lifo_stack_tb: done, errors");
         $finish;
      end
   end

   // effect of one operation on the predicted stack, and the item it returns
   function automatic bls_pkg::rsp_type apply_stack_op(bls_pkg::req_type op);
      bls_pkg::rsp_type   rsp;
      bls_pkg::count_type lim;
      bls_pkg::count_type top;
      rsp = '0;
      lim = (stack_cap > STACK_DEPTH) ? bls_pkg::count_type'(STACK_DEPTH) : stack_cap;
      case (op.mode)
         bls_pkg::MODE_PUSH: begin
            if (stack_level >= lim) begin
               rsp.status = bls_pkg::STATUS_OVERFLOW;
            end else begin
               stack_words[stack_level[5:0]] = op.push_value;
               stack_level = stack_level + 1'b1;
            end
         end
         bls_pkg::MODE_POP, bls_pkg::MODE_PEEK: begin
            if (stack_level == 0) begin
               rsp.status = bls_pkg::STATUS_UNDERFLOW;
            end else begin
               top = stack_level - 1'b1;
               rsp.read_value = stack_words[top[5:0]];
               if (op.mode == bls_pkg::MODE_POP) stack_level = top;
            end
         end
         default: ;
      endcase
      rsp.entry_count = stack_level;
      rsp.is_full     = (stack_level >= lim);
      rsp.is_empty    = (stack_level == 0);
      return rsp;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (error_count < MAX_PRINTS)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // offer one item; valid stays high after acceptance for the next call
   task automatic send_op(logic [1:0] op, logic [31:0] word);
      bls_pkg::req_type item;
      item.mode       = op;
      item.push_value = word;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      due_stack_rsps.push_back(apply_stack_op(item));
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle_stack();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (due_stack_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(bls_pkg::count_type cap);
      settle_stack();
      @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= cap;
      do @(posedge clock); while (!csr_if.ready);
      stack_cap = cap;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      rsp_if.ready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always begin
      @(long_hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // compare each returned item against the oldest prediction
   always @(posedge clock) begin : check_rsp
      bls_pkg::rsp_type got;
      bls_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (due_stack_rsps.size() == 0) begin
            report_mismatch("item with no prediction, entry_count", got.entry_count, 0);
         end else begin
            want = due_stack_rsps.pop_front();
            if (got.read_value !== want.read_value)
               report_mismatch("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.entry_count !== want.entry_count)
               report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.is_full !== want.is_full)
               report_mismatch("is_full", got.is_full, want.is_full);
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", got.is_empty, want.is_empty);
         end
      end
   end

   // empty-stack reads, unused mode, extreme words, fill and drain
   task automatic test_stack_basics();
      send_op(bls_pkg::MODE_POP, 32'h0);
      send_op(bls_pkg::MODE_PEEK, 32'h1234_5678);
      send_op(MODE_UNUSED, 32'hFFFF_FFFF);
      send_op(bls_pkg::MODE_PUSH, 32'h8000_0000);
      send_op(bls_pkg::MODE_PUSH, 32'h7FFF_FFFF);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0000);
      send_op(bls_pkg::MODE_PUSH, 32'hFFFF_FFFF);
      send_op(bls_pkg::MODE_PEEK, 32'h0);
      send_op(MODE_UNUSED, 32'h5555_5555);
      repeat (4) send_op(bls_pkg::MODE_POP, 32'hAAAA_AAAA);
      send_op(bls_pkg::MODE_POP, 32'h0);
      send_op(bls_pkg::MODE_PEEK, 32'h0);
   endtask

   // overflow at small limits, limit lowered under the fill level, limit 1 and 0
   task automatic test_capacity_corners();
      write_capacity(7'd2);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0011);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0022);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0033);
      write_capacity(7'd1);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0044);
      send_op(bls_pkg::MODE_POP, 32'h0);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0055);
      send_op(bls_pkg::MODE_POP, 32'h0);
      send_op(bls_pkg::MODE_PUSH, 32'hDEAD_BEEF);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0066);
      send_op(bls_pkg::MODE_POP, 32'h0);
      write_capacity(7'd0);
      send_op(bls_pkg::MODE_PUSH, 32'h0000_0077);
      send_op(bls_pkg::MODE_POP, 32'h0);
   endtask

   // runs of push-heavy or pop-heavy traffic, so the stack fills and drains
   task automatic test_random_traffic(bls_pkg::count_type cap, int count, int send_pct,
                                      int recv_pct);
      int         sent;
      int         run_len;
      int         pick;
      bit         push_heavy;
      logic [1:0] op;
      write_capacity(cap);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         run_len    = $urandom_range(1, 24);
         push_heavy = ($urandom_range(2) != 0);
         repeat (run_len) begin
            pick = $urandom_range(99);
            if (pick < 4)
               op = MODE_UNUSED;
            else if (pick < 14)
               op = bls_pkg::MODE_PEEK;
            else if (pick < (push_heavy ? 80 : 35))
               op = bls_pkg::MODE_PUSH;
            else
               op = bls_pkg::MODE_POP;
            send_op(op, random_word());
            sent++;
         end
      end
   endtask

   // receiver holds off while pushes keep coming, then the sender waits it out
   task automatic test_full_backpressure();
      write_capacity(7'd64);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      -> long_hold_go;
      repeat (40) send_op(bls_pkg::MODE_PUSH, random_word());
      repeat (20) send_op(bls_pkg::MODE_POP, 32'h0);
      settle_stack();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      hold_active    = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      stack_level    = '0;
      stack_cap      = bls_pkg::CAP_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_stack_basics();
      test_capacity_corners();
      test_random_traffic(7'd64, 350, 25, 87);
      test_random_traffic(bls_pkg::count_type'($urandom_range(2, 64)), 350, 87, 25);
      test_random_traffic(7'd127, 350, 0, 0);
      test_random_traffic(7'd3, 60, 0, 0);
      test_full_backpressure();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("bounded_lifo_stack_tb: done, clean");
      end else begin
         $display("bounded_lifo_stack_tb: done, errors");
      end
      $finish;
   end

endmodule
